/* rtl/core/hhfp_pkg.sv */
// Package for the HTTP header field parser.
// Holds the transfer structs, the event codes and the character constants.
// It has no dependencies.
package hhfp_pkg;

    // Event codes reported for every accepted item.
    typedef enum logic [3:0] {
        EV_SKIP        = 4'd0,
        EV_NAME        = 4'd1,
        EV_VALUE       = 4'd2,
        EV_COLON       = 4'd3,
        EV_LINE_END    = 4'd4,
        EV_DISCARD     = 4'd5,
        EV_COMMIT      = 4'd6,
        EV_DONE        = 4'd7,
        EV_DONE_BEFORE = 4'd8,
        EV_ERROR       = 4'd9,
        EV_CLEARED     = 4'd10
    } hdr_event_t;

    // Operation codes of the input transfer.
    localparam logic OP_PARSE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Characters that the parser distinguishes.
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Line break run counter values.
    localparam logic [2:0] RUN_PENDING = 3'd3;
    localparam logic [2:0] RUN_DONE    = 3'd4;
    localparam logic [2:0] RUN_MAX     = 3'd7;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
        logic       last_of_chunk;
    } hdr_in_t;

    typedef struct packed {
        hdr_event_t event_res;
        logic [7:0] echo_byte;
        logic       chunk_incomplete;
    } hdr_out_t;

endpackage

/* rtl/core/http_header_field_parser.sv */
// Top level of the HTTP header field parser.
// Classifies header bytes one at a time; depends on hhfp_pkg.
//
// The parser takes one transfer per clock cycle on the s_ channel while its
// result register can take it, and gives exactly one registered result
// transfer on the m_ channel for each. Each byte of the "Name: value" lines is
// tagged as skipped whitespace, name byte, value byte, colon, line end,
// discarded name, field commit, header done (after or before the byte) or
// error, and the byte itself is echoed so that downstream logic can capture
// the name and value text. A run of CR or LF bytes is counted and the fourth
// one in a row ends the header. Names are limited to NAME_LIMIT bytes, and
// once a name has reached that limit value bytes are refused as well. A clear
// transfer returns the parser to the name state and answers with the cleared
// event. Throughput is one item per cycle unless m_ready stalls the result
// register: the classification and the state update are a few byte compares
// and an increment and compare of the name length counter, which is just wide
// enough to hold NAME_LIMIT, done between the parser state and the result
// register. The result register sits behind a skid-free ready path, so a new
// item is taken whenever the result register is empty or its content is being
// taken in the same cycle.
module http_header_field_parser
    import hhfp_pkg::*;
#(
    parameter int NAME_LIMIT = 256
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  hdr_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output hdr_out_t m_data
);

    // The name length counter must be able to hold the limit itself.
    localparam int LEN_W = $clog2(NAME_LIMIT + 1);
    localparam logic [LEN_W-1:0] LIMIT_LEN = LEN_W'(NAME_LIMIT);

    // Parser state.
    logic             in_value_reg,      in_value_next;
    logic [2:0]       run_reg,           run_next;
    logic [LEN_W-1:0] name_len_reg,      name_len_next;
    logic             value_started_reg, value_started_next;

    // Result register.
    logic     m_valid_reg;
    hdr_out_t m_data_reg;
    hdr_out_t res_next;

    logic accept;

    // A new item is taken when the result register is empty or is being
    // emptied in this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Classification of the byte and the resulting state update.
    always_comb begin
        logic       is_ws;
        logic       is_brk;
        logic       is_colon;
        logic       below_limit;
        logic [2:0] run_bumped;
        hdr_event_t ev;

        is_ws       = (s_data.data_byte == CHAR_SPACE) || (s_data.data_byte == CHAR_TAB);
        is_brk      = (s_data.data_byte == CHAR_CR) || (s_data.data_byte == CHAR_LF);
        is_colon    = (s_data.data_byte == CHAR_COLON);
        below_limit = (name_len_reg < LIMIT_LEN);
        // The run saturates so that done is not reported again until broken.
        run_bumped  = (run_reg == RUN_MAX) ? RUN_MAX : run_reg + 3'd1;

        in_value_next      = in_value_reg;
        run_next           = run_reg;
        name_len_next      = name_len_reg;
        value_started_next = value_started_reg;
        ev                 = EV_ERROR;

        if (s_data.operation == OP_CLEAR) begin
            in_value_next      = 1'b0;
            run_next           = 3'd0;
            name_len_next      = '0;
            value_started_next = 1'b0;
            ev                 = EV_CLEARED;
        end else if (!in_value_reg) begin
            // Name state.
            priority if (is_ws) begin
                ev = (name_len_reg == '0) ? EV_SKIP : EV_ERROR;
            end else if (is_brk) begin
                run_next = run_bumped;
                if (run_bumped == RUN_DONE) begin
                    ev = EV_DONE;
                end else if (name_len_reg != '0) begin
                    name_len_next = '0;
                    ev            = EV_DISCARD;
                end else begin
                    ev = EV_LINE_END;
                end
            end else if (!is_colon && below_limit) begin
                if (run_reg == RUN_PENDING) begin
                    ev = EV_DONE_BEFORE;
                end else begin
                    run_next      = 3'd0;
                    name_len_next = name_len_reg + LEN_W'(1);
                    ev            = EV_NAME;
                end
            end else if (is_colon) begin
                if (run_reg == RUN_PENDING) begin
                    ev = EV_ERROR;
                end else begin
                    run_next      = 3'd0;
                    in_value_next = 1'b1;
                    ev            = EV_COLON;
                end
            end else begin
                // Name has reached its limit and the byte is not a colon.
                run_next = 3'd0;
                ev       = EV_ERROR;
            end
        end else begin
            // Value state.
            priority if (is_ws) begin
                ev = value_started_reg ? EV_VALUE : EV_SKIP;
            end else if (!is_brk && below_limit) begin
                if (run_reg == RUN_PENDING) begin
                    ev = EV_DONE_BEFORE;
                end else begin
                    run_next           = 3'd0;
                    value_started_next = 1'b1;
                    ev                 = EV_VALUE;
                end
            end else if (is_brk) begin
                run_next      = run_bumped;
                in_value_next = 1'b0;
                if (name_len_reg != '0 && value_started_reg) begin
                    name_len_next      = '0;
                    value_started_next = 1'b0;
                    ev                 = EV_COMMIT;
                end else begin
                    ev = EV_LINE_END;
                end
            end else begin
                // Value byte after an over-long name is refused.
                ev = EV_ERROR;
            end
        end

        res_next.event_res        = ev;
        res_next.echo_byte        = (s_data.operation == OP_CLEAR) ? 8'h00 : s_data.data_byte;
        res_next.chunk_incomplete = (s_data.operation == OP_PARSE) && s_data.last_of_chunk
                                    && (ev <= EV_COMMIT);
    end

    // Parser state and result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_value_reg      <= 1'b0;
            run_reg           <= 3'd0;
            name_len_reg      <= '0;
            value_started_reg <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (accept) begin
                in_value_reg      <= in_value_next;
                run_reg           <= run_next;
                name_len_reg      <= name_len_next;
                value_started_reg <= value_started_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= res_next;
        end
    end

    // The name length counter never passes the limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        name_len_reg <= LIMIT_LEN)
        else $error("name length beyond limit");

    // A clear returns all parser state to the name state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_data.operation == OP_CLEAR) |=>
            !in_value_reg && (run_reg == 3'd0) && (name_len_reg == '0) && !value_started_reg)
        else $error("clear did not restore the name state");

    // A done event leaves the line break run at exactly four.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (res_next.event_res == EV_DONE) |=> run_reg == RUN_DONE)
        else $error("done reported without a run of four line breaks");

    // An accepted item always shows up in the result register next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg && (m_data_reg == $past(res_next)))
        else $error("accepted item lost");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the HTTP header field parser.
// Drives header bytes and clear transfers, predicts each result and checks it.
// Depends on hhfp_pkg and http_header_field_parser.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hhfp_pkg::*;

    // The parser is built with its default name limit; the predictor uses the same value.
    localparam int NAME_LIMIT = 256;
    // Generous ceiling on the run length.
    localparam int CYCLE_LIMIT = 200000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    hdr_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    hdr_out_t m_data;

    http_header_field_parser #(
        .NAME_LIMIT(NAME_LIMIT)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Header bytes waiting to be sent, and the results expected from the parser, oldest first.
    hdr_in_t  byte_queue[$];
    hdr_out_t pending_results[$];

    // Percentages of cycles in which the sender and the receiver hold back.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    // The predictor's own copy of the parser state.
    logic        hdr_in_value;
    logic [2:0]  hdr_break_run;
    int unsigned hdr_name_len;
    logic        hdr_value_started;

    initial begin
        hdr_in_value      = 1'b0;
        hdr_break_run     = '0;
        hdr_name_len      = 0;
        hdr_value_started = 1'b0;
    end

    // Works out the result that the parser gives for one accepted transfer, and moves the
    // predictor's state on exactly as the parser should.
    function automatic hdr_out_t classify_byte(input hdr_in_t item);
        hdr_out_t   res;
        hdr_event_t ev;
        logic [7:0] b;
        logic       is_ws;
        logic       is_brk;
        b      = item.data_byte;
        is_ws  = (b == CHAR_SPACE) || (b == CHAR_TAB);
        is_brk = (b == CHAR_CR) || (b == CHAR_LF);
        if (item.operation == OP_CLEAR) begin
            // A clear puts every part of the state back to its reset value.
            hdr_in_value         = 1'b0;
            hdr_break_run        = '0;
            hdr_name_len         = 0;
            hdr_value_started    = 1'b0;
            res.event_res        = EV_CLEARED;
            res.echo_byte        = '0;
            res.chunk_incomplete = 1'b0;
            return res;
        end
        if (!hdr_in_value) begin
            if (is_ws) begin
                // Leading whitespace is skipped, whitespace inside a name is an error.
                ev = (hdr_name_len == 0) ? EV_SKIP : EV_ERROR;
            end else if (is_brk) begin
                if (hdr_break_run < RUN_MAX) hdr_break_run = hdr_break_run + 3'd1;
                if (hdr_break_run == RUN_DONE) begin
                    ev = EV_DONE;
                end else if (hdr_name_len != 0) begin
                    hdr_name_len = 0;
                    ev = EV_DISCARD;
                end else begin
                    ev = EV_LINE_END;
                end
            end else if (b != CHAR_COLON && hdr_name_len < NAME_LIMIT) begin
                if (hdr_break_run == RUN_PENDING) begin
                    ev = EV_DONE_BEFORE;
                end else begin
                    hdr_break_run = '0;
                    hdr_name_len++;
                    ev = EV_NAME;
                end
            end else if (b == CHAR_COLON) begin
                if (hdr_break_run == RUN_PENDING) begin
                    ev = EV_ERROR;
                end else begin
                    hdr_break_run = '0;
                    hdr_in_value  = 1'b1;
                    ev = EV_COLON;
                end
            end else begin
                // The name is at its limit and the byte is not a colon.
                hdr_break_run = '0;
                ev = EV_ERROR;
            end
        end else begin
            if (is_ws) begin
                ev = hdr_value_started ? EV_VALUE : EV_SKIP;
            end else if (!is_brk && hdr_name_len < NAME_LIMIT) begin
                if (hdr_break_run == RUN_PENDING) begin
                    ev = EV_DONE_BEFORE;
                end else begin
                    hdr_break_run     = '0;
                    hdr_value_started = 1'b1;
                    ev = EV_VALUE;
                end
            end else if (is_brk) begin
                if (hdr_break_run < RUN_MAX) hdr_break_run = hdr_break_run + 3'd1;
                hdr_in_value = 1'b0;
                if (hdr_name_len != 0 && hdr_value_started) begin
                    hdr_name_len      = 0;
                    hdr_value_started = 1'b0;
                    ev = EV_COMMIT;
                end else begin
                    // The name and value marks are kept on a bare line end.
                    ev = EV_LINE_END;
                end
            end else begin
                // A name at its limit refuses every value byte that is not whitespace.
                ev = EV_ERROR;
            end
        end
        res.event_res        = ev;
        res.echo_byte        = b;
        res.chunk_incomplete = item.last_of_chunk && (ev <= EV_COMMIT);
        return res;
    endfunction

    // Driver. At each rising edge the transfer on offer is recorded if it was taken, and the
    // next one is put up unless the sender chooses to idle. Valid is only lowered when the
    // previous transfer has gone, so a held item never drops.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pending_results.push_back(classify_byte(s_data));
            end
            if (!s_valid || s_ready) begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= byte_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver. Each result transfer is compared field by field with the oldest
    // expectation; ready is redrawn every cycle from the current idling percentage.
    always @(posedge aclk) begin
        hdr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result: event %0d byte %02h incomplete %0b",
                             m_data.event_res, m_data.echo_byte, m_data.chunk_incomplete);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_data.event_res !== want.event_res ||
                    m_data.echo_byte !== want.echo_byte ||
                    m_data.chunk_incomplete !== want.chunk_incomplete) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: expected event %0d byte %02h incomplete %0b",
                                 want.event_res, want.echo_byte, want.chunk_incomplete);
                        $display("          actual   event %0d byte %02h incomplete %0b",
                                 m_data.event_res, m_data.echo_byte, m_data.chunk_incomplete);
                    end
                end
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: a hung parser or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic put_item(input logic op, input logic [7:0] b, input logic last);
        hdr_in_t item;
        item.operation     = op;
        item.data_byte     = b;
        item.last_of_chunk = last;
        byte_queue.push_back(item);
    endtask

    // Queues one parse transfer, marking roughly one in eight as the end of a chunk.
    task automatic put_byte(input logic [7:0] b);
        put_item(OP_PARSE, b, $urandom_range(7) == 0);
    endtask

    // Any byte that can stand in a name: not whitespace, not a line break, not a colon.
    function automatic logic [7:0] name_char();
        logic [7:0] b;
        do begin
            b = ($urandom_range(1) == 0) ? 8'($urandom_range(126, 33)) : 8'($urandom_range(255));
        end while (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_CR || b == CHAR_LF ||
                   b == CHAR_COLON);
        return b;
    endfunction

    // Any byte that can stand in a value: everything except a line break.
    function automatic logic [7:0] value_char();
        logic [7:0] b;
        do begin
            b = ($urandom_range(3) == 0) ? CHAR_SPACE : 8'($urandom_range(255));
        end while (b == CHAR_CR || b == CHAR_LF);
        return b;
    endfunction

    task automatic put_line_end();
        int unsigned pick;
        pick = $urandom_range(5);
        if (pick < 4) begin
            put_byte(CHAR_CR);
            put_byte(CHAR_LF);
        end else if (pick == 4) begin
            put_byte(CHAR_LF);
        end else begin
            put_byte(CHAR_CR);
        end
    endtask

    // One well-formed "Name: value" line with random content.
    task automatic put_field(input int unsigned name_len, input int unsigned value_len);
        int unsigned n;
        n = $urandom_range(3);
        repeat (n) put_byte(($urandom_range(1) == 0) ? CHAR_SPACE : CHAR_TAB);
        repeat (name_len) put_byte(name_char());
        put_byte(CHAR_COLON);
        n = $urandom_range(2);
        repeat (n) put_byte(($urandom_range(1) == 0) ? CHAR_SPACE : CHAR_TAB);
        repeat (value_len) put_byte(value_char());
        put_line_end();
    endtask

    // A header of a few fields, usually closed by an empty line, sometimes ended early by an
    // ordinary byte after three line breaks, sometimes left open.
    task automatic put_header();
        int unsigned fields;
        int unsigned ending;
        fields = $urandom_range(4, 1);
        repeat (fields) put_field($urandom_range(12, 1), $urandom_range(20));
        ending = $urandom_range(9);
        if (ending < 6) begin
            put_byte(CHAR_CR);
            put_byte(CHAR_LF);
            if ($urandom_range(3) == 0) put_byte(CHAR_CR);
        end else if (ending < 8) begin
            put_byte(CHAR_CR);
            put_byte(name_char());
        end
        if ($urandom_range(2) == 0) begin
            put_item(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    // A name that runs to its limit and beyond, after which value bytes are refused too.
    task automatic put_long_field();
        repeat (NAME_LIMIT) put_byte(name_char());
        repeat (3) put_byte(name_char());
        put_byte(CHAR_SPACE);
        put_byte(CHAR_COLON);
        repeat (3) put_byte(value_char() | 8'h01);
        put_byte(CHAR_TAB);
        put_byte(CHAR_CR);
        repeat (2) put_byte(name_char());
        put_item(OP_CLEAR, 8'h00, 1'b0);
    endtask

    // Random bytes with the special characters well represented.
    task automatic put_noise();
        int unsigned n;
        int unsigned pick;
        logic [7:0]  b;
        n = $urandom_range(8, 1);
        repeat (n) begin
            pick = $urandom_range(9);
            case (pick)
                0: b = CHAR_SPACE;
                1: b = CHAR_TAB;
                2: b = CHAR_CR;
                3: b = CHAR_LF;
                4: b = CHAR_COLON;
                default: b = 8'($urandom_range(255));
            endcase
            put_byte(b);
        end
    endtask

    task automatic put_directed();
        put_item(OP_CLEAR, 8'hFF, 1'b1);      // clear with a non-zero byte echoes zero
        put_item(OP_PARSE, CHAR_SPACE, 1'b0); // leading whitespace of a name is skipped
        put_item(OP_PARSE, CHAR_TAB, 1'b1);
        put_item(OP_PARSE, "H", 1'b0);
        put_item(OP_PARSE, CHAR_SPACE, 1'b1); // whitespace inside a name
        put_item(OP_PARSE, "o", 1'b0);
        put_item(OP_PARSE, CHAR_COLON, 1'b1);
        put_item(OP_PARSE, CHAR_SPACE, 1'b0); // leading whitespace of a value
        put_item(OP_PARSE, 8'hFF, 1'b1);
        put_item(OP_PARSE, CHAR_TAB, 1'b0);   // whitespace inside a value is kept
        put_item(OP_PARSE, 8'h00, 1'b0);
        put_item(OP_PARSE, CHAR_CR, 1'b1);    // field commit
        put_item(OP_PARSE, CHAR_LF, 1'b0);
        put_item(OP_PARSE, "X", 1'b0);
        put_item(OP_PARSE, CHAR_CR, 1'b0);    // name without a colon is discarded
        put_item(OP_PARSE, CHAR_LF, 1'b0);
        put_item(OP_PARSE, CHAR_CR, 1'b0);
        put_item(OP_PARSE, CHAR_COLON, 1'b1); // colon after three line breaks
        put_item(OP_PARSE, "a", 1'b1);        // header done before this byte
        put_item(OP_PARSE, CHAR_LF, 1'b1);    // fourth line break ends the header
        put_item(OP_PARSE, CHAR_CR, 1'b0);    // the run goes on past four, no second done
        put_item(OP_PARSE, "k", 1'b0);
        put_item(OP_PARSE, CHAR_COLON, 1'b0);
        put_item(OP_PARSE, CHAR_LF, 1'b1);    // line end with a name but no value
        put_item(OP_PARSE, "z", 1'b0);
    endtask

    task automatic wait_for_drain();
        do @(negedge aclk);
        while (byte_queue.size() != 0 || s_valid || pending_results.size() != 0);
    endtask

    // Stimulus sequencer. Three phases with different idling; between phases the sender
    // holds off until every expected result has arrived.
    initial begin
        int unsigned target;
        int unsigned pick;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            @(negedge aclk);
            case (phase)
                0: begin
                    send_idle_pct = 36;
                    recv_idle_pct = 84;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_idle_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0) put_directed();
            target = byte_queue.size() + 350;
            while (byte_queue.size() < target) begin
                pick = $urandom_range(99);
                if (pick < 65) begin
                    put_header();
                end else if (pick < 85) begin
                    put_noise();
                end else if (pick < 92) begin
                    put_item(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
                end else begin
                    // Broken lines: a bare name, or a colon with no name in front.
                    if ($urandom_range(1) == 0) begin
                        repeat ($urandom_range(5, 1)) put_byte(name_char());
                    end else begin
                        put_byte(CHAR_COLON);
                        repeat ($urandom_range(4)) put_byte(value_char());
                    end
                    put_line_end();
                end
                if (phase != 1 && byte_queue.size() >= target / 2 &&
                    byte_queue.size() < target / 2 + 30 && $urandom_range(3) == 0) begin
                    put_long_field();
                end
            end
            wait_for_drain();
        end
        // Give any stray result time to arrive so that it is caught.
        repeat (16) @(negedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
